// ===== src/arm_alu_multiply_branch_execute_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ARM execute block
// Shared property forms; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ARM_ALU_MULTIPLY_BRANCH_EXECUTE_DEFINES_SVH
`define ARM_ALU_MULTIPLY_BRANCH_EXECUTE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AMABE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AMABE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/amabe_pkg.sv =====
// ----------------------------------------------------------------------------
// amabe_pkg
// Types, codes and decode helpers of the ARM execute block.
// ----------------------------------------------------------------------------
package amabe_pkg;

  typedef enum logic [2:0] {
    CLS_OTHER, CLS_DP, CLS_MUL, CLS_MULL, CLS_BRANCH
  } cls_t;

  typedef struct packed {
    logic [31:0] word;
    cls_t        cls;
  } qitem_t;

  typedef struct packed {
    logic        extra_cycle;
    logic        flush;
    logic [3:0]  flags_out;
    logic [31:0] wr_b_value;
    logic [3:0]  wr_b_index;
    logic        wr_b_en;
    logic [31:0] wr_a_value;
    logic [3:0]  wr_a_index;
    logic        wr_a_en;
    logic        handled;
    logic        cond_passed;
  } res_t;

  localparam int unsigned FL_N = 3;
  localparam int unsigned FL_Z = 2;
  localparam int unsigned FL_C = 1;
  localparam int unsigned FL_V = 0;

  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_PL = 4'd5;
  localparam logic [3:0] COND_VS = 4'd6;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LS = 4'd9;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_ADC = 4'd5;
  localparam logic [3:0] OP_SBC = 4'd6;
  localparam logic [3:0] OP_RSC = 4'd7;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;
  localparam logic [3:0] OP_MVN = 4'd15;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  function automatic cls_t classify(logic [31:0] w);
    cls_t        c;
    logic [27:0] op;
    op = w[27:0];
    c  = CLS_OTHER;
    case (op[27:26])
      2'b00: begin
        if (!op[25] && (op & 28'hFF00FF0) == 28'h1200F10) c = CLS_OTHER;
        else if (!op[25] && (op & 28'h10000F0) == 28'h0000090)
          c = op[23] ? CLS_MULL : CLS_MUL;
        else if (!op[25] && (op & 28'h10000F0) == 28'h1000090) c = CLS_OTHER;
        else if (!op[25] && (op & 28'h04000F0) == 28'h00000B0) c = CLS_OTHER;
        else if (!op[25] && (op & 28'h04000F0) == 28'h04000B0) c = CLS_OTHER;
        else if (!op[25] && (op & 28'h00000D0) == 28'h00000D0) c = CLS_OTHER;
        else if (!op[20] && op[24:23] == 2'b10) c = CLS_OTHER;
        else c = CLS_DP;
      end
      2'b10:   c = op[25] ? CLS_BRANCH : CLS_OTHER;
      default: c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic cond_ok(logic [3:0] cond, logic [3:0] f);
    logic n, z, c, v, r;
    n = f[FL_N];
    z = f[FL_Z];
    c = f[FL_C];
    v = f[FL_V];
    case (cond)
      COND_EQ: r = z;
      COND_NE: r = !z;
      COND_CS: r = c;
      COND_CC: r = !c;
      COND_MI: r = n;
      COND_PL: r = !n;
      COND_VS: r = v;
      COND_VC: r = !v;
      COND_HI: r = c && !z;
      COND_LS: r = !c || z;
      COND_GE: r = (n == v);
      COND_LT: r = (n != v);
      COND_GT: r = !z && (n == v);
      COND_LE: r = z || (n != v);
      COND_AL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Returns {carry_out, result}.
  function automatic logic [32:0] barrel(logic [31:0] v, logic [1:0] typ,
                                         logic [7:0] amt, logic by_reg,
                                         logic cin);
    logic [63:0] wide;
    logic [32:0] ext;
    logic [31:0] r;
    logic        co;
    wide = '0;
    ext  = '0;
    r    = v;
    co   = cin;
    case (typ)
      SH_LSL: begin
        wide = {32'd0, v} << amt[4:0];
        if (amt == 8'd0) begin
          r = v; co = cin;
        end else if (amt < 8'd32) begin
          r = wide[31:0]; co = wide[32];
        end else begin
          r = '0; co = (amt == 8'd32) ? v[0] : 1'b0;
        end
      end
      SH_LSR: begin
        ext = {v, 1'b0} >> amt[4:0];
        if (by_reg && amt == 8'd0) begin
          r = v; co = cin;
        end else if (!by_reg && amt == 8'd0) begin
          r = '0; co = v[31];
        end else if (amt < 8'd32) begin
          r = ext[32:1]; co = ext[0];
        end else begin
          r = '0; co = (amt == 8'd32) ? v[31] : 1'b0;
        end
      end
      SH_ASR: begin
        ext = 33'($signed({v, 1'b0}) >>> amt[4:0]);
        if (by_reg && amt == 8'd0) begin
          r = v; co = cin;
        end else if (amt != 8'd0 && amt < 8'd32) begin
          r = ext[32:1]; co = ext[0];
        end else begin
          r = {32{v[31]}}; co = v[31];
        end
      end
      default: begin
        wide = {v, v} >> amt[4:0];
        if (!by_reg && amt == 8'd0) begin
          r = {cin, v[31:1]}; co = v[0];
        end else if (amt == 8'd0) begin
          r = v; co = cin;
        end else begin
          r = wide[31:0]; co = wide[31];
        end
      end
    endcase
    return {co, r};
  endfunction

endpackage

// ===== src/amabe_front.sv =====
// ----------------------------------------------------------------------------
// amabe_front
// Accepts instruction words, classifies them and holds them in a
// two-entry queue for the execute side.
// ----------------------------------------------------------------------------
module amabe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_word,
  output logic                 q_valid,
  output amabe_pkg::qitem_t    q_item,
  input  logic                 q_pop
);
  import amabe_pkg::*;

  qitem_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{word: in_word, cls: classify(in_word)};
    end
  end

endmodule

// ===== src/amabe_back.sv =====
// ----------------------------------------------------------------------------
// amabe_back
// Execute side: condition test, shifter and ALU, registered multiplier,
// branch, register file, flags and the result register.
// ----------------------------------------------------------------------------
module amabe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  amabe_pkg::qitem_t    q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output amabe_pkg::res_t      out_res
);
  import amabe_pkg::*;

  logic [31:0] rf_r [16];
  logic [3:0]  flags_r, flags_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        out_res_r;
  logic        m_v_r, m_v_nxt;
  logic [31:0] m_w_r;
  logic        m_long_r;
  logic [63:0] m_prod_r;

  logic        out_can, done, start_mul, pass, regsh, logical, sc, cin;
  logic [31:0] w, op1, op2, shv, a_in, b_in, lres, r;
  logic [32:0] bres, sum;
  logic        ci;
  logic [7:0]  amt;
  logic [3:0]  opc, rot;
  logic [31:0] imm_rot;
  logic [63:0] prod_full, acc, p;
  logic        sgn;
  logic [65:0] prod66;
  res_t        res;

  assign out_can   = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;
  assign w         = q_item.word;
  assign cin       = flags_r[FL_C];
  assign pass      = cond_ok(w[31:28], flags_r);

  // shifter operand
  always_comb begin
    regsh   = !w[25] && w[4];
    rot     = w[11:8];
    imm_rot = ({24'd0, w[7:0]} >> {rot, 1'b0}) |
              ({24'd0, w[7:0]} << (6'd32 - {1'b0, rot, 1'b0}));
    op1     = rf_r[w[19:16]] + ((regsh && w[19:16] == REG_PC) ? 32'd4 : 32'd0);
    shv     = rf_r[w[3:0]] + ((regsh && w[3:0] == REG_PC) ? 32'd4 : 32'd0);
    amt     = regsh ? rf_r[w[11:8]][7:0] : {3'd0, w[11:7]};
    bres    = barrel(shv, w[6:5], amt, regsh, cin);
    if (w[25]) begin
      op2 = (rot == 4'd0) ? {24'd0, w[7:0]} : imm_rot;
      sc  = (rot == 4'd0) ? cin : imm_rot[31];
    end else begin
      op2 = bres[31:0];
      sc  = bres[32];
    end
  end

  // ALU
  always_comb begin
    opc     = w[24:21];
    logical = 1'b0;
    lres    = '0;
    a_in    = op1;
    b_in    = op2;
    ci      = 1'b0;
    case (opc)
      OP_AND, OP_TST: begin lres = op1 & op2;  logical = 1'b1; end
      OP_EOR, OP_TEQ: begin lres = op1 ^ op2;  logical = 1'b1; end
      OP_SUB, OP_CMP: begin b_in = ~op2; ci = 1'b1; end
      OP_RSB:         begin a_in = op2; b_in = ~op1; ci = 1'b1; end
      OP_ADD, OP_CMN: begin ci = 1'b0; end
      OP_ADC:         begin ci = cin; end
      OP_SBC:         begin b_in = ~op2; ci = cin; end
      OP_RSC:         begin a_in = op2; b_in = ~op1; ci = cin; end
      OP_ORR:         begin lres = op1 | op2;  logical = 1'b1; end
      OP_MOV:         begin lres = op2;        logical = 1'b1; end
      OP_BIC:         begin lres = op1 & ~op2; logical = 1'b1; end
      default:        begin lres = ~op2;       logical = 1'b1; end
    endcase
    sum = {1'b0, a_in} + {1'b0, b_in} + {32'd0, ci};
    r   = logical ? lres : sum[31:0];
  end

  // multiplier, before the product register
  always_comb begin
    sgn       = (q_item.cls == CLS_MULL) && w[22];
    prod66    = 66'($signed({sgn & rf_r[w[3:0]][31], rf_r[w[3:0]]}) *
                    $signed({sgn & rf_r[w[11:8]][31], rf_r[w[11:8]]}));
    prod_full = prod66[63:0];
  end

  // accumulate, after the product register
  always_comb begin
    acc = m_long_r ? {rf_r[m_w_r[19:16]], rf_r[m_w_r[15:12]]}
                   : {32'd0, rf_r[m_w_r[15:12]]};
    p   = m_prod_r + (m_w_r[21] ? acc : 64'd0);
  end

  always_comb begin
    q_pop     = 1'b0;
    start_mul = 1'b0;
    done      = 1'b0;
    flags_nxt = flags_r;
    res       = '0;
    if (m_v_r) begin
      if (out_can) begin
        done            = 1'b1;
        res.cond_passed = 1'b1;
        res.handled     = 1'b1;
        res.wr_a_en     = 1'b1;
        if (m_long_r) begin
          res.wr_a_index = m_w_r[15:12];
          res.wr_a_value = p[31:0];
          res.wr_b_en    = 1'b1;
          res.wr_b_index = m_w_r[19:16];
          res.wr_b_value = p[63:32];
          if (m_w_r[20]) begin
            flags_nxt[FL_N] = p[63];
            flags_nxt[FL_Z] = (p == 64'd0);
          end
        end else begin
          res.wr_a_index = m_w_r[19:16];
          res.wr_a_value = p[31:0];
          if (m_w_r[20]) begin
            flags_nxt[FL_N] = p[31];
            flags_nxt[FL_Z] = (p[31:0] == 32'd0);
          end
        end
      end
    end else if (q_valid && out_can) begin
      q_pop = 1'b1;
      if (pass && (q_item.cls == CLS_MUL || q_item.cls == CLS_MULL)) begin
        start_mul = 1'b1;
      end else begin
        done            = 1'b1;
        res.cond_passed = pass;
        res.handled     = (q_item.cls != CLS_OTHER);
        if (pass && q_item.cls == CLS_DP) begin
          res.extra_cycle = regsh;
          if (w[20] && w[15:12] != REG_PC) begin
            flags_nxt[FL_N] = r[31];
            flags_nxt[FL_Z] = (r == 32'd0);
            flags_nxt[FL_C] = logical ? sc : sum[32];
            flags_nxt[FL_V] = logical ? flags_r[FL_V]
                                      : ((a_in[31] ^ r[31]) & (b_in[31] ^ r[31]));
          end
          if (opc[3:2] != 2'b10) begin
            res.wr_a_en    = 1'b1;
            res.wr_a_index = w[15:12];
            res.wr_a_value = r;
          end
        end else if (pass && q_item.cls == CLS_BRANCH) begin
          res.wr_a_en    = 1'b1;
          res.wr_a_index = REG_PC;
          res.wr_a_value = rf_r[REG_PC] + {{6{w[23]}}, w[23:0], 2'b00};
          if (w[24]) begin
            res.wr_b_en    = 1'b1;
            res.wr_b_index = REG_LR;
            res.wr_b_value = rf_r[REG_PC] - 32'd4;
          end
        end
      end
    end
    res.flags_out = flags_nxt;
    res.flush     = (res.wr_a_en && res.wr_a_index == REG_PC) ||
                    (res.wr_b_en && res.wr_b_index == REG_PC);
  end

  always_comb begin
    m_v_nxt   = start_mul || (m_v_r && !out_can);
    out_v_nxt = done || (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      m_v_r   <= 1'b0;
      flags_r <= 4'd0;
      for (int i = 0; i < 16; i++) rf_r[i] <= 32'd0;
    end else begin
      out_v_r <= out_v_nxt;
      m_v_r   <= m_v_nxt;
      flags_r <= flags_nxt;
      if (res.wr_a_en) rf_r[res.wr_a_index] <= res.wr_a_value;
      if (res.wr_b_en) rf_r[res.wr_b_index] <= res.wr_b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_res_r <= res;
    if (start_mul) begin
      m_w_r    <= w;
      m_long_r <= (q_item.cls == CLS_MULL);
      m_prod_r <= prod_full;
    end
  end

endmodule

// ===== src/arm_alu_multiply_branch_execute.sv =====
// ----------------------------------------------------------------------------
// arm_alu_multiply_branch_execute
// ARM-state execute block for data processing, multiply and branch.
// ----------------------------------------------------------------------------
// One request on the in_ channel carries one 32-bit instruction word; the
// block returns exactly one result request per word on the out_ channel, in
// order. The front classifies each word and drops it into a two-entry queue;
// the back tests the condition against its NZCV flags and executes against
// its own 16-entry register file, updating both at the end of the cycle.
// A word passes the queue and then the result register; a taken multiply
// also passes the product register. Throughput is one instruction per cycle
// while the result register can take one; an executed multiply or long
// multiply holds the back through the 33x33 multiply and 64-bit accumulate.
// Reset clears the queue, the result register, the flags and every register.
// When the receiver stalls, the result register holds its request, the back
// stops popping, the queue fills and in_tready drops once both entries are
// occupied.
// ----------------------------------------------------------------------------
`include "arm_alu_multiply_branch_execute_defines.svh"

module arm_alu_multiply_branch_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] instr_word
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] cond_passed, [1] handled, [2] wr_a_en, [6:3] wr_a_index,
  // [38:7] wr_a_value, [39] wr_b_en, [43:40] wr_b_index, [75:44] wr_b_value,
  // [79:76] flags_out, [80] flush, [81] extra_cycle, [87:82] zero
  output logic [87:0] out_tdata
);
  import amabe_pkg::*;

  logic   q_valid;
  logic   q_pop;
  qitem_t q_item;
  res_t   res;

  // classify and queue
  amabe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_word  (in_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // execute and hold the result
  amabe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // res_t is declared MSB-first in the reverse of the port order
  assign out_tdata = {6'd0, res};

  `AMABE_ASSERT_IMPL(a_flush_pc, out_tvalid && out_tdata[80], (out_tdata[2] && out_tdata[6:3] == REG_PC) || (out_tdata[39] && out_tdata[43:40] == REG_PC), "flush without a write to r15")
  `AMABE_ASSERT_IMPL(a_fail_quiet, out_tvalid && !out_tdata[0], !out_tdata[2] && !out_tdata[39] && !out_tdata[81], "failed condition produced side effects")
  `AMABE_ASSERT_IMPL(a_write_handled, out_tvalid && (out_tdata[2] || out_tdata[39]), out_tdata[1] && out_tdata[0], "register write from unhandled instruction")
  `AMABE_ASSERT_NEXT(a_pop_bounded, q_pop && !q_valid, 1'b0, "queue popped while empty")

endmodule

// ===== test/arm_alu_multiply_branch_execute_test.sv =====
// ----------------------------------------------------------------------------
// arm_alu_multiply_branch_execute_test
// Self-checking bench for the ARM execute block.
// ----------------------------------------------------------------------------
// The bench runs a short directed list first, then random instruction words.
// The directed list covers every opcode, the shifter corners, condition NV,
// unhandled classes, multiplies, long multiplies and branches.
// An internal copy of the register file and the NZCV flags predicts each
// result when its request is accepted. The monitor compares every result
// request, field by field, against the oldest prediction.
// Both sides idle in random bursts. Once in the run, the receiver holds off
// long enough that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module arm_alu_multiply_branch_execute_test;
  import amabe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned CALM_TAIL   = 150;
  localparam logic [3:0]  COND_NEVER  = 4'hF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;

  arm_alu_multiply_branch_execute u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // Predicted architectural state.
  logic [31:0] model_regs [16];
  logic [3:0]  model_nzcv;

  logic [31:0] word_queue [$];
  res_t        result_queue [$];
  int unsigned error_count = 0;
  int unsigned words_taken = 0;
  int unsigned cycle_count = 0;
  bit          words_loaded = 1'b0;
  bit          word_taken_now = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic cond_holds(logic [3:0] cc, logic [3:0] f);
    logic n, z, c, v;
    n = f[FL_N];
    z = f[FL_Z];
    c = f[FL_C];
    v = f[FL_V];
    case (cc)
      COND_EQ: return z;
      COND_NE: return !z;
      COND_CS: return c;
      COND_CC: return !c;
      COND_MI: return n;
      COND_PL: return !n;
      COND_VS: return v;
      COND_VC: return !v;
      COND_HI: return c && !z;
      COND_LS: return !c || z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic cls_t instr_kind(logic [31:0] w);
    case (w[27:26])
      2'b00: begin
        if (!w[25]) begin
          if ((w[27:0] & 28'hFF00FF0) == 28'h1200F10) return CLS_OTHER;
          if ((w[27:0] & 28'h10000F0) == 28'h0000090) return w[23] ? CLS_MULL : CLS_MUL;
          if ((w[27:0] & 28'h10000F0) == 28'h1000090) return CLS_OTHER;
          if ((w[27:0] & 28'h04000F0) == 28'h00000B0) return CLS_OTHER;
          if ((w[27:0] & 28'h04000F0) == 28'h04000B0) return CLS_OTHER;
          if ((w[7:4] & 4'hD) == 4'hD) return CLS_OTHER;
        end
        if (!w[20] && w[24:21] >= OP_TST && w[24:21] <= OP_CMN) return CLS_OTHER;
        return CLS_DP;
      end
      2'b10:   return w[25] ? CLS_BRANCH : CLS_OTHER;
      default: return CLS_OTHER;
    endcase
  endfunction

  // Returns {carry, value}.
  function automatic logic [32:0] shifter(logic [31:0] v, logic [1:0] kind,
                                          logic [7:0] amt, logic by_reg, logic cin);
    logic [63:0] wide;
    logic [4:0]  n;
    if (kind != SH_LSL && kind != SH_ROR && !by_reg && amt == 0) amt = 8'd32;
    if (kind == SH_ROR && !by_reg && amt == 0) return {v[0], cin, v[31:1]};
    if (amt == 0) return {cin, v};
    case (kind)
      SH_LSL: begin
        wide = {32'd0, v} << amt;
        if (amt < 32) return {wide[32], wide[31:0]};
        return {(amt == 32) ? v[0] : 1'b0, 32'd0};
      end
      SH_LSR: begin
        if (amt < 32) return {v[amt - 1], v >> amt};
        return {(amt == 32) ? v[31] : 1'b0, 32'd0};
      end
      SH_ASR: begin
        if (amt < 32) return {v[amt - 1], 32'($signed(v) >>> amt)};
        return {v[31], {32{v[31]}}};
      end
      default: begin
        n = amt[4:0];
        if (n == 0) return {v[31], v};
        return {v[n - 1], (v >> n) | (v << (6'd32 - n))};
      end
    endcase
  endfunction

  // Returns {carry, overflow, sum}.
  function automatic logic [33:0] add_cv(logic [31:0] a, logic [31:0] b, logic cin);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + 33'(cin);
    return {s[32], ((a ^ s[31:0]) & (b ^ s[31:0])) >> 31 != 0, s[31:0]};
  endfunction

  task automatic execute_word(input logic [31:0] w, output res_t r);
    cls_t        kind;
    logic        cin, sc, c, v, logical;
    logic [3:0]  f, opc, rd, rn, rm;
    logic [31:0] op1, op2, val, off;
    logic [32:0] sh;
    logic [33:0] ad;
    logic [63:0] x, y, p;
    logic [4:0]  rot;
    r    = '0;
    f    = model_nzcv;
    kind = instr_kind(w);
    cin  = f[FL_C];
    r.cond_passed = cond_holds(w[31:28], f);
    r.handled     = (kind != CLS_OTHER);
    if (r.cond_passed) begin
      case (kind)
        CLS_DP: begin
          opc = w[24:21];
          rd  = w[15:12];
          rn  = w[19:16];
          rm  = w[3:0];
          op1 = model_regs[rn];
          sc  = cin;
          c   = cin;
          v   = f[FL_V];
          ad  = '0;
          if (w[25]) begin
            rot = {w[11:8], 1'b0};
            op2 = {24'd0, w[7:0]};
            if (rot != 0) begin
              op2 = (op2 >> rot) | (op2 << (6'd32 - rot));
              sc  = op2[31];
            end
          end else begin
            op2 = model_regs[rm];
            if (w[4]) begin
              r.extra_cycle = 1'b1;
              if (rn == REG_PC) op1 += 32'd4;
              if (rm == REG_PC) op2 += 32'd4;
              sh = shifter(op2, w[6:5], model_regs[w[11:8]][7:0], 1'b1, cin);
            end else begin
              sh = shifter(op2, w[6:5], {3'd0, w[11:7]}, 1'b0, cin);
            end
            {sc, op2} = sh;
          end
          logical = 1'b1;
          case (opc)
            OP_AND, OP_TST: val = op1 & op2;
            OP_EOR, OP_TEQ: val = op1 ^ op2;
            OP_ORR:         val = op1 | op2;
            OP_MOV:         val = op2;
            OP_BIC:         val = op1 & ~op2;
            OP_MVN:         val = ~op2;
            default: begin
              logical = 1'b0;
              case (opc)
                OP_SUB, OP_CMP: ad = add_cv(op1, ~op2, 1'b1);
                OP_RSB:         ad = add_cv(op2, ~op1, 1'b1);
                OP_ADD, OP_CMN: ad = add_cv(op1, op2, 1'b0);
                OP_ADC:         ad = add_cv(op1, op2, cin);
                OP_SBC:         ad = add_cv(op1, ~op2, cin);
                default:        ad = add_cv(op2, ~op1, cin);
              endcase
              {c, v, val} = ad;
            end
          endcase
          if (logical) c = sc;
          if (w[20] && rd != REG_PC) f = {val[31], val == 0, c, v};
          if (opc < OP_TST || opc > OP_CMN) begin
            r.wr_a_en = 1'b1; r.wr_a_index = rd; r.wr_a_value = val;
          end
        end
        CLS_MUL: begin
          val = model_regs[w[3:0]] * model_regs[w[11:8]];
          if (w[21]) val += model_regs[w[15:12]];
          if (w[20]) begin
            f[FL_N] = val[31];
            f[FL_Z] = (val == 0);
          end
          r.wr_a_en = 1'b1; r.wr_a_index = w[19:16]; r.wr_a_value = val;
        end
        CLS_MULL: begin
          x = {32'd0, model_regs[w[3:0]]};
          y = {32'd0, model_regs[w[11:8]]};
          if (w[22]) begin
            x[63:32] = {32{x[31]}};
            y[63:32] = {32{y[31]}};
          end
          p = x * y;
          if (w[21]) p += {model_regs[w[19:16]], model_regs[w[15:12]]};
          if (w[20]) begin
            f[FL_N] = p[63];
            f[FL_Z] = (p == 0);
          end
          r.wr_a_en = 1'b1; r.wr_a_index = w[15:12]; r.wr_a_value = p[31:0];
          r.wr_b_en = 1'b1; r.wr_b_index = w[19:16]; r.wr_b_value = p[63:32];
        end
        CLS_BRANCH: begin
          off = {{6{w[23]}}, w[23:0], 2'b00};
          r.wr_a_en = 1'b1; r.wr_a_index = REG_PC;
          r.wr_a_value = model_regs[REG_PC] + off;
          if (w[24]) begin
            r.wr_b_en = 1'b1; r.wr_b_index = REG_LR;
            r.wr_b_value = model_regs[REG_PC] - 32'd4;
          end
        end
        default: ;
      endcase
    end
    // Apply the low write first so the high word wins when both hit one register.
    if (r.wr_a_en) model_regs[r.wr_a_index] = r.wr_a_value;
    if (r.wr_b_en) model_regs[r.wr_b_index] = r.wr_b_value;
    model_nzcv  = f;
    r.flags_out = f;
    r.flush = (r.wr_a_en && r.wr_a_index == REG_PC) || (r.wr_b_en && r.wr_b_index == REG_PC);
  endtask

  // --------------------------------------------------------------------------
  // Instruction encoders
  // --------------------------------------------------------------------------
  function automatic logic [31:0] enc_dp(logic [3:0] cc, logic imm, logic [3:0] opc,
                                         logic s, logic [3:0] rn, logic [3:0] rd,
                                         logic [11:0] op2);
    return {cc, 2'b00, imm, opc, s, rn, rd, op2};
  endfunction

  // Register operand shifted by register Rs.
  function automatic logic [11:0] shift_by_rs(logic [3:0] rs, logic [1:0] kind,
                                              logic [3:0] rm);
    return {rs, 1'b0, kind, 1'b1, rm};
  endfunction

  function automatic logic [11:0] imm_shift(logic [4:0] amt, logic [1:0] kind, logic [3:0] rm);
    return {amt, kind, 1'b0, rm};
  endfunction

  function automatic logic [31:0] enc_mul(logic [3:0] cc, logic acc, logic s, logic [3:0] rd,
                                          logic [3:0] rn, logic [3:0] rs, logic [3:0] rm);
    return {cc, 6'b000000, acc, s, rd, rn, rs, 4'b1001, rm};
  endfunction

  function automatic logic [31:0] enc_mull(logic [3:0] cc, logic sgn, logic acc, logic s,
                                           logic [3:0] hi, logic [3:0] lo,
                                           logic [3:0] rs, logic [3:0] rm);
    return {cc, 5'b00001, sgn, acc, s, hi, lo, rs, 4'b1001, rm};
  endfunction

  function automatic logic [31:0] enc_branch(logic [3:0] cc, logic link, logic [23:0] off);
    return {cc, 3'b101, link, off};
  endfunction

  function automatic logic [3:0] any_cond();
    return ($urandom_range(0, 1) != 0) ? COND_AL : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] random_word();
    int unsigned pick;
    logic [3:0]  rs;
    pick = $urandom_range(0, 99);
    rs   = 4'($urandom);
    if (pick < 25)
      return enc_dp(any_cond(), 1'b1, 4'($urandom), 1'($urandom), 4'($urandom),
                    4'($urandom_range(0, 14)), 12'($urandom));
    if (pick < 45)
      return enc_dp(any_cond(), 1'b0, 4'($urandom), 1'($urandom), 4'($urandom),
                    4'($urandom), imm_shift(5'($urandom), 2'($urandom), 4'($urandom)));
    if (pick < 58)
      return enc_dp(any_cond(), 1'b0, 4'($urandom), 1'($urandom), 4'($urandom),
                    4'($urandom), shift_by_rs(rs, 2'($urandom), 4'($urandom)));
    if (pick < 68)
      return enc_mul(any_cond(), 1'($urandom), 1'($urandom), 4'($urandom),
                     4'($urandom), 4'($urandom), 4'($urandom));
    if (pick < 78)
      return enc_mull(any_cond(), 1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                      4'($urandom), 4'($urandom), 4'($urandom));
    if (pick < 86)
      return enc_branch(any_cond(), 1'($urandom), 24'($urandom));
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    // Load registers with edge values.
    word_queue.push_back(enc_dp(COND_AL, 1'b1, OP_MVN, 1'b1, 4'd0, 4'd1, 12'h000));
    word_queue.push_back(enc_dp(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd2, 12'h2FF));
    word_queue.push_back(enc_dp(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd3, 12'h102));
    word_queue.push_back(enc_dp(COND_AL, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd4, 12'h0FF));
    // Every opcode with the S bit, register operand.
    for (k = 0; k < 16; k++)
      word_queue.push_back(enc_dp(COND_AL, 1'b0, 4'(k), 1'b1, 4'd1, 4'(5 + (k % 8)),
                                  imm_shift(5'(k * 2), 2'(k), 4'(1 + k % 4))));
    // Register-specified shifts, reading r15 as stored plus four.
    word_queue.push_back(enc_dp(COND_AL, 1'b0, OP_ADD, 1'b1, REG_PC, 4'd6,
                                shift_by_rs(4'd4, SH_ROR, REG_PC)));
    // Flag-setting write to r15: result lands, flags hold.
    word_queue.push_back(enc_dp(COND_AL, 1'b1, OP_SUB, 1'b1, 4'd1, REG_PC, 12'h001));
    word_queue.push_back(enc_dp(COND_NE, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd7, 12'hFFF));
    word_queue.push_back(enc_dp(COND_NEVER, 1'b1, OP_MOV, 1'b0, 4'd0, 4'd7, 12'h001));
    word_queue.push_back(enc_mul(COND_AL, 1'b1, 1'b1, 4'd8, 4'd1, 4'd2, 4'd1));
    // Long multiply with RdLo equal to RdHi, then signed accumulate.
    word_queue.push_back(enc_mull(COND_AL, 1'b0, 1'b0, 1'b1, 4'd9, 4'd9, 4'd1, 4'd1));
    word_queue.push_back(enc_mull(COND_GE, 1'b1, 1'b1, 1'b1, 4'd10, 4'd11, 4'd1, 4'd2));
    word_queue.push_back(enc_branch(COND_AL, 1'b1, 24'h800000));
    word_queue.push_back(enc_branch(COND_AL, 1'b0, 24'h7FFFFF));
    // Unhandled classes: branch-exchange, load, software interrupt, status read.
    word_queue.push_back(32'hE12FFF10);
    word_queue.push_back(32'hE5900000);
    word_queue.push_back(32'hEF000000);
    word_queue.push_back(32'hE10F0000);
    for (k = 0; k < 1400; k++) word_queue.push_back(random_word());
    words_loaded = 1'b1;
  end

  // Reset once.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: hold each request until accepted, idle in short bursts.
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(negedge clk) begin
    if (rst_n && words_loaded && (word_taken_now || !in_tvalid)) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (word_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (word_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap  <= $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= word_queue.pop_front();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: short stall bursts plus one long hold-off to back up the block.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!long_hold_done && words_taken >= 300) begin
      long_hold_done <= 1'b1;
      stall_left     <= 200;
      out_tready     <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (word_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input acceptance, check on result acceptance.
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      error_count++;
    end
  endfunction

  initial begin
    for (int i = 0; i < 16; i++) model_regs[i] = '0;
    model_nzcv = '0;
  end

  always @(posedge clk) begin
    res_t predicted, seen;
    cycle_count++;
    word_taken_now = rst_n && in_tvalid && in_tready;
    if (word_taken_now) begin
      execute_word(in_tdata, predicted);
      result_queue.push_back(predicted);
      words_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen = res_t'(out_tdata[81:0]);
      if (result_queue.size() == 0) begin
        $error("result with no instruction outstanding: %h", out_tdata);
        error_count++;
      end else begin
        predicted = result_queue.pop_front();
        check_field("cond_passed", predicted.cond_passed, seen.cond_passed);
        check_field("handled", predicted.handled, seen.handled);
        check_field("wr_a_en", predicted.wr_a_en, seen.wr_a_en);
        check_field("wr_a_index", predicted.wr_a_index, seen.wr_a_index);
        check_field("wr_a_value", predicted.wr_a_value, seen.wr_a_value);
        check_field("wr_b_en", predicted.wr_b_en, seen.wr_b_en);
        check_field("wr_b_index", predicted.wr_b_index, seen.wr_b_index);
        check_field("wr_b_value", predicted.wr_b_value, seen.wr_b_value);
        check_field("flags_out", predicted.flags_out, seen.flags_out);
        check_field("flush", predicted.flush, seen.flush);
        check_field("extra_cycle", predicted.extra_cycle, seen.extra_cycle);
      end
      check_field("padding", 32'd0, 32'(out_tdata[87:82]));
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // End of run: drain, let the pipeline settle, report.
  // --------------------------------------------------------------------------
  initial begin
    wait (words_loaded);
    do @(posedge clk);
    while (word_queue.size() != 0 || in_tvalid || result_queue.size() != 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && result_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
